>>> design/ketl_pkg.sv
// Package for the keyed event threshold limiter.
// Holds widths, register indexes, reset constants and shared structs.
package ketl_pkg;
  localparam int TableEntries = 64;
  localparam int KeyBits = 32;
  localparam int SpanW = 24;
  localparam int CountNeededW = 16;
  localparam int CountW = 32;
  localparam int TimeW = 32;
  localparam int CfgIdxW = 2;
  localparam logic [SpanW-1:0] MaxlimitReset = 24'd86400;

  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxlimit = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCountNeeded = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture item and start scan
    logic scan;      // examine current scan entry
    logic rd_hit;    // read chosen entry
    logic mod_start; // begin count % n
    logic mod_step;  // one remainder step
    logic commit;    // write back and form result
  } ketl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;     // an entry (hit, reuse or free) is available
    logic mod_done;
  } ketl_sts_t;
endpackage

>>> design/ketl_ctrl.sv
// Controller state machine of the keyed event threshold limiter.
// Depends on ketl_pkg for the command and status structs.
module ketl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                is_tick,
  input  logic                is_plain,
  input  logic                out_free,
  input  ketl_pkg::ketl_sts_t sts,
  output ketl_pkg::ketl_cmd_t cmd,
  output logic                idle,
  output logic                res_load
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_READ = 7'b0000100,
    S_MODS = 7'b0001000,
    S_MOD  = 7'b0010000,
    S_COMM = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    res_load = 1'b0;
    idle = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_fire && !is_tick) begin
          if (is_plain) state_next = S_OUT;
          else begin
            cmd.load = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_READ;
      end
      S_READ: begin
        cmd.rd_hit = 1'b1;
        state_next = S_MODS;
      end
      S_MODS: begin
        cmd.mod_start = 1'b1;
        state_next = sts.found ? S_MOD : S_OUT;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_next = S_COMM;
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> design/ketl_dp.sv
// Datapath of the keyed event threshold limiter: entry table, scan, remainder unit.
// Depends on ketl_pkg; driven by ketl_ctrl through command and status structs.
module ketl_dp #(
  parameter int TABLE_ENTRIES = ketl_pkg::TableEntries,
  parameter int KEY_BITS = ketl_pkg::KeyBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick,
  input  logic                                plain,
  input  logic [31:0]                         key_in,
  input  logic [ketl_pkg::SpanW-1:0]          threshold_seconds,
  input  logic [ketl_pkg::SpanW-1:0]          limit_seconds,
  input  logic [ketl_pkg::SpanW-1:0]          maxlimit_seconds,
  input  logic [ketl_pkg::CountNeededW-1:0]   count_needed,
  input  ketl_pkg::ketl_cmd_t                 cmd,
  output ketl_pkg::ketl_sts_t                 sts,
  output logic                                res_pass,
  output logic                                res_full,
  output logic [ketl_pkg::CountW-1:0]         res_count
);
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = ketl_pkg::CountW;
  localparam int TW = ketl_pkg::TimeW;

  logic [TW-1:0] now_seconds;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
  logic [CntW+TW-1:0] data_mem [TABLE_ENTRIES];

  logic [KEY_BITS-1:0] key;
  logic [IdxW:0] scan_idx;
  logic [KEY_BITS-1:0] rd_key;
  logic [CntW+TW-1:0] rd_data;
  logic rd_valid, rd_ok;
  logic [IdxW-1:0] rd_idx;
  logic hit_f, same_f, free_f;
  logic [IdxW-1:0] hit_i, same_i, free_i;
  logic fresh;
  logic [IdxW-1:0] sel;
  logic [CntW-1:0] cnt;
  logic [TW-1:0] dl;
  logic [CntW-1:0] rem;
  logic [5:0] mod_bit;
  logic [CntW-1:0] cnt_new;
  logic [ketl_pkg::CountNeededW-1:0] n;
  logic modes;

  assign modes = (threshold_seconds != '0) || (limit_seconds != '0);
  assign n = (count_needed == '0) ? ketl_pkg::CountNeededW'(1) : count_needed;

  // Key extension: input keys are 32 bits; compare the low KEY_BITS.
  logic [63:0] key_ext;
  assign key_ext = {32'd0, key_in};

  // Table read port is registered; scan compares the entry read last cycle.
  always_ff @(posedge clk) begin
    rd_key  <= key_mem[scan_idx[IdxW-1:0]];
    rd_data <= data_mem[cmd.rd_hit ? sel : scan_idx[IdxW-1:0]];
    rd_valid <= entry_valid[scan_idx[IdxW-1:0]];
    rd_idx  <= scan_idx[IdxW-1:0];
    rd_ok   <= cmd.scan && (scan_idx < (IdxW+1)'(TABLE_ENTRIES));
  end

  logic live, match;
  assign live = rd_valid && (!modes || rd_data[TW-1:0] == rd_data[TW-1:0] &&
                (now_seconds - rd_data[TW-1:0]) >= 32'h8000_0000);
  assign match = rd_valid && rd_key == key;

  assign sts.scan_last = (scan_idx == (IdxW+1)'(TABLE_ENTRIES));
  assign sts.found = hit_f || same_f || free_f;
  assign sts.mod_done = (mod_bit == 6'd0);
  assign sel = hit_f ? hit_i : (same_f ? same_i : free_i);

  // A reused or free entry starts over from count zero.
  assign fresh = !hit_f;
  assign cnt = fresh ? '0 : rd_data[CntW+TW-1:TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
      entry_valid <= '0;
      scan_idx <= '0;
    end else begin
      if (tick) now_seconds <= now_seconds + 1'b1;
      if (cmd.load) begin
        key <= key_ext[KEY_BITS-1:0];
        scan_idx <= '0;
        hit_f <= 1'b0; same_f <= 1'b0; free_f <= 1'b0;
      end
      if (cmd.scan && !sts.scan_last) scan_idx <= scan_idx + 1'b1;
      if (rd_ok) begin
        if (match && live && !hit_f) begin hit_f <= 1'b1; hit_i <= rd_idx; end
        if (match && !live && !same_f) begin same_f <= 1'b1; same_i <= rd_idx; end
        if (!live && !free_f) begin free_f <= 1'b1; free_i <= rd_idx; end
      end
      if (cmd.mod_start) begin
        dl <= fresh ? now_seconds : rd_data[TW-1:0];
        cnt_new <= (cnt == '1) ? cnt : cnt + 1'b1;
        rem <= '0;
        mod_bit <= 6'd32;
        res_full <= !sts.found;
        res_pass <= 1'b0;
        res_count <= '0;
      end
      if (cmd.mod_step && mod_bit != 6'd0) begin : mod_step_blk
        // One restoring step of cnt_new % n per cycle.
        logic [CntW:0] t;
        t = {rem, cnt_new[mod_bit[4:0] - 5'd1]};
        if (t >= {17'd0, n}) rem <= CntW'(t - {17'd0, n});
        else rem <= t[CntW-1:0];
        mod_bit <= mod_bit - 6'd1;
      end
      if (cmd.commit) begin : commit_blk
        logic p;
        logic [TW-1:0] d;
        logic lim;
        p = 1'b1;
        d = dl;
        lim = (limit_seconds != '0);
        if (threshold_seconds != '0) begin
          if (cnt_new == 32'd1) d = now_seconds + TW'(threshold_seconds);
          if (rem != '0) begin p = 1'b0; lim = 1'b0; end
        end
        if (lim) begin
          if (cnt_new == 32'd1) d = now_seconds + TW'(maxlimit_seconds);
          if (cnt_new == {16'd0, n}) d = now_seconds + TW'(limit_seconds);
          p = (cnt_new <= {16'd0, n});
        end
        entry_valid[sel] <= 1'b1;
        key_mem[sel] <= key;
        data_mem[sel] <= {cnt_new, d};
        res_pass <= p;
        res_full <= 1'b0;
        res_count <= cnt_new;
      end
      if (plain) begin
        res_pass <= 1'b1; res_full <= 1'b0; res_count <= '0;
      end
    end
  end
endmodule

>>> design/keyed_event_threshold_limiter.sv
// Keyed event threshold limiter. One item in flight at a time; a tick gives no beat.
// A keyed event scans one table entry per cycle, reads the chosen entry, runs the
// remainder unit, writes the entry back and then loads its result beat. With the
// table full the remainder and write-back are skipped. A keyless event goes straight
// to its result beat. The next beat can be taken as soon as that beat turns valid.
// Synchronous reset clears time, entry valid bits and config to reset values.
module keyed_event_threshold_limiter #(
  parameter int TABLE_ENTRIES = ketl_pkg::TableEntries,
  parameter int KEY_BITS = ketl_pkg::KeyBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // event_key[31:0]
  input  logic [1:0]  s_tuser,  // operation, key_present
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // event_count[31:0]
  output logic [1:0]  m_tuser,  // pass_event, table_full
  input  logic        cfg_we,
  input  logic [ketl_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ketl_pkg::SpanW-1:0]   cfg_data
);
  logic [ketl_pkg::SpanW-1:0] threshold_seconds, limit_seconds, maxlimit_seconds;
  logic [ketl_pkg::CountNeededW-1:0] count_needed;
  ketl_pkg::ketl_cmd_t cmd;
  ketl_pkg::ketl_sts_t sts;
  logic idle, res_load, in_fire, pass, full;
  logic [ketl_pkg::CountW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_seconds <= '0;
      limit_seconds <= '0;
      maxlimit_seconds <= ketl_pkg::MaxlimitReset;
      count_needed <= ketl_pkg::CountNeededW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ketl_pkg::RegThreshold: threshold_seconds <= cfg_data;
        ketl_pkg::RegLimit: limit_seconds <= cfg_data;
        ketl_pkg::RegMaxlimit: maxlimit_seconds <= cfg_data;
        ketl_pkg::RegCountNeeded: count_needed <= cfg_data[ketl_pkg::CountNeededW-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = idle;
  assign in_fire = s_tvalid && s_tready;

  ketl_ctrl u_ctrl (
    .clk, .rst, .in_fire,
    .is_tick(s_tuser[0]), .is_plain(!s_tuser[1]),
    .out_free(!m_tvalid || m_tready),
    .sts, .cmd, .idle, .res_load
  );

  ketl_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk, .rst,
    .tick(in_fire && s_tuser[0]),
    .plain(in_fire && !s_tuser[0] && !s_tuser[1]),
    .key_in(s_tdata),
    .threshold_seconds, .limit_seconds, .maxlimit_seconds, .count_needed,
    .cmd, .sts, .res_pass(pass), .res_full(full), .res_count(count)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (res_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (res_load) begin
      m_tdata <= count;
      m_tuser <= {full, pass};
    end
  end
endmodule

>>> design/ketl_checker.sv
// Port-level checker for the keyed event threshold limiter.
// Bound to the top level; sees its ports only.
module ketl_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0] m_tuser
);
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == '0) else $error("full passed");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("beat dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid)) else $error("accept");
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("reset");
endmodule

bind keyed_event_threshold_limiter ketl_checker u_ketl_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);

>>> dv/testbench.sv
// Self-checking testbench for keyed_event_threshold_limiter.
// It predicts each result from its own copy of the key table and compares it
// with the output beats. It depends only on ketl_pkg and the block itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [ketl_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [ketl_pkg::SpanW-1:0]   cfg_data = '0;

  keyed_event_threshold_limiter dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic        op;
    logic        key_present;
    logic [31:0] key;
  } event_beat_t;

  typedef struct packed {
    logic        pass;
    logic        full;
    logic [31:0] count;
  } verdict_t;

  event_beat_t pending_beats[$];
  verdict_t    expected_verdicts[$];
  int          errors = 0;
  int          sender_idle = 0;
  int          receiver_idle = 0;

  // Predictor copy of the configuration and table.
  logic [31:0] thr_span, lim_span, maxlim_span;
  logic [15:0] needed;
  logic [31:0] now_sec;
  logic        tbl_valid[ketl_pkg::TableEntries];
  logic [31:0] tbl_key[ketl_pkg::TableEntries];
  logic [31:0] tbl_count[ketl_pkg::TableEntries];
  logic [31:0] tbl_deadline[ketl_pkg::TableEntries];

  function automatic logic entry_live(int i);
    logic [31:0] diff;
    diff = now_sec - tbl_deadline[i];
    if (!tbl_valid[i]) return 1'b0;
    if (thr_span == 0 && lim_span == 0) return 1'b1;
    return diff[31];
  endfunction

  function automatic logic apply_limit(int i, logic [31:0] c, logic [31:0] n);
    if (c == 1) tbl_deadline[i] = now_sec + maxlim_span;
    if (c == n) tbl_deadline[i] = now_sec + lim_span;
    return c <= n;
  endfunction

  task automatic predict_verdict(input event_beat_t b);
    int hit, same, free_idx;
    logic live, pass;
    logic [31:0] c, n;
    verdict_t v;
    hit = -1;
    same = -1;
    free_idx = -1;
    if (b.op) begin
      now_sec = now_sec + 1;
      return;
    end
    if (!b.key_present) begin
      v = '{pass: 1'b1, full: 1'b0, count: '0};
      expected_verdicts.push_back(v);
      return;
    end
    for (int i = 0; i < ketl_pkg::TableEntries; i++) begin
      live = entry_live(i);
      if (tbl_valid[i] && tbl_key[i] == b.key) begin
        if (live) begin
          if (hit < 0) hit = i;
        end else if (same < 0) begin
          same = i;
        end
      end
      if (!live && free_idx < 0) free_idx = i;
    end
    if (hit < 0) begin
      hit = (same >= 0) ? same : free_idx;
      if (hit < 0) begin
        v = '{pass: 1'b0, full: 1'b1, count: '0};
        expected_verdicts.push_back(v);
        return;
      end
      tbl_valid[hit] = 1'b1;
      tbl_key[hit] = b.key;
      tbl_count[hit] = '0;
      tbl_deadline[hit] = now_sec;
    end
    if (tbl_count[hit] != 32'hFFFF_FFFF) tbl_count[hit] = tbl_count[hit] + 1;
    c = tbl_count[hit];
    n = (needed == 0) ? 32'd1 : {16'd0, needed};
    if (thr_span != 0) begin
      if (c == 1) tbl_deadline[hit] = now_sec + thr_span;
      if (c % n != 0) pass = 1'b0;
      else if (lim_span != 0) pass = apply_limit(hit, c, n);
      else pass = 1'b1;
    end else if (lim_span != 0) begin
      pass = apply_limit(hit, c, n);
    end else begin
      pass = 1'b1;
    end
    v = '{pass: pass, full: 1'b0, count: c};
    expected_verdicts.push_back(v);
  endtask

  // Driver: predicts on each accepted beat, then presents the next one.
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_verdict({s_tuser[0], s_tuser[1], s_tdata});
        void'(pending_beats.pop_front());
        next_valid = 1'b0;
      end
      if (!next_valid && pending_beats.size() > 0 &&
          $urandom_range(99) >= sender_idle) begin
        next_valid = 1'b1;
        s_tdata <= pending_beats[0].key;
        s_tuser <= {pending_beats[0].key_present, pending_beats[0].op};
      end
      s_tvalid <= next_valid;
    end
  end

  // Monitor: random backpressure and a field-by-field check of each beat.
  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result beat: tuser %b count %0d", m_tuser, m_tdata);
          errors++;
        end else begin
          v = expected_verdicts.pop_front();
          if (m_tuser[0] !== v.pass) begin
            $error("pass_event expected %0d actual %0d", v.pass, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== v.full) begin
            $error("table_full expected %0d actual %0d", v.full, m_tuser[1]);
            errors++;
          end
          if (m_tdata !== v.count) begin
            $error("event_count expected %0d actual %0d", v.count, m_tdata);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  task automatic add_beat(input logic op, input logic kp, input logic [31:0] key);
    event_beat_t b;
    b = '{op: op, key_present: kp, key: key};
    pending_beats.push_back(b);
  endtask

  task automatic write_reg(input logic [ketl_pkg::CfgIdxW-1:0] idx,
                           input logic [ketl_pkg::SpanW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ketl_pkg::RegThreshold:   thr_span = {8'd0, val};
      ketl_pkg::RegLimit:       lim_span = {8'd0, val};
      ketl_pkg::RegMaxlimit:    maxlim_span = {8'd0, val};
      ketl_pkg::RegCountNeeded: needed = val[15:0];
      default: ;
    endcase
  endtask

  // Waits until every beat has been sent and every expected result checked, then
  // lets the clock run on before returning.
  task automatic wait_drained();
    while (pending_beats.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_modes(input logic [23:0] thr, input logic [23:0] lim,
                           input logic [23:0] maxl, input logic [23:0] n);
    wait_drained();
    write_reg(ketl_pkg::RegThreshold, thr);
    write_reg(ketl_pkg::RegLimit, lim);
    write_reg(ketl_pkg::RegMaxlimit, maxl);
    write_reg(ketl_pkg::RegCountNeeded, n);
  endtask

  // Mostly repeats of a few keys, with ticks, keyless events and stray keys.
  task automatic random_beats(input int count);
    logic [31:0] pool[6];
    int r;
    for (int i = 0; i < 6; i++) pool[i] = $urandom();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 22) add_beat(1'b1, $urandom_range(1), $urandom());
      else if (r < 28) add_beat(1'b0, 1'b0, $urandom());
      else if (r < 88) add_beat(1'b0, 1'b1, pool[$urandom_range(5)]);
      else add_beat(1'b0, 1'b1, $urandom());
    end
  endtask

  task automatic pick_idling(input int phase);
    case (phase % 3)
      0: begin sender_idle = 19; receiver_idle = 53; end
      1: begin sender_idle = 53; receiver_idle = 19; end
      default: begin sender_idle = 0; receiver_idle = 0; end
    endcase
  endtask

  initial begin
    thr_span = 0;
    lim_span = 0;
    maxlim_span = {8'd0, ketl_pkg::MaxlimitReset};
    needed = 16'd1;
    now_sec = 0;
    for (int i = 0; i < ketl_pkg::TableEntries; i++) tbl_valid[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: keyless event, ticks, extreme keys, repeats, reset settings.
    pick_idling(0);
    add_beat(1'b0, 1'b0, 32'h0);
    add_beat(1'b0, 1'b1, 32'h0);
    add_beat(1'b0, 1'b1, 32'hFFFF_FFFF);
    add_beat(1'b0, 1'b1, 32'h0);
    add_beat(1'b1, 1'b0, 32'h0);
    add_beat(1'b1, 1'b1, 32'hFFFF_FFFF);
    add_beat(1'b0, 1'b1, 32'hFFFF_FFFF);
    add_beat(1'b0, 1'b0, 32'hFFFF_FFFF);
    set_modes(24'd2, 24'd0, 24'd86400, 24'd3);
    for (int i = 0; i < 8; i++) add_beat(1'b0, 1'b1, 32'h5A5A_0001);
    for (int i = 0; i < 3; i++) add_beat(1'b1, 1'b0, 32'h0);
    for (int i = 0; i < 4; i++) add_beat(1'b0, 1'b1, 32'h5A5A_0001);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_modes(24'd3, 24'd0, 24'd86400, 24'd2);
        1: set_modes(24'd0, 24'd4, 24'd6, 24'd3);
        2: set_modes(24'd5, 24'd8, 24'd10, 24'd2);
        3: set_modes(24'd0, 24'd0, 24'd0, 24'd1);
        4: set_modes(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h00FFFF);
        5: set_modes(24'd1, 24'd2, 24'd0, 24'd0);
        6: set_modes(24'd2, 24'd3, 24'd5, 24'hFF0004);
        default: set_modes(24'd0, 24'd1, 24'd3, 24'd2);
      endcase
      pick_idling((phase * 3) / 8);
      // Modes off or very long spans: fill the table past its size.
      if (phase == 3 || phase == 4)
        for (int k = 0; k < ketl_pkg::TableEntries + 6; k++)
          add_beat(1'b0, 1'b1, $urandom());
      random_beats(phase == 3 || phase == 4 ? 40 : 75);
    end

    wait_drained();
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end
endmodule

>>> filelist.f
design/ketl_pkg.sv
design/ketl_ctrl.sv
design/ketl_dp.sv
design/keyed_event_threshold_limiter.sv
design/ketl_checker.sv
dv/testbench.sv
